@@ hdl/siphash_bloom_filter_insert_defines.svh @@
// assertion macros for the bloom filter insert block
// no dependencies
`ifndef SIPHASH_BLOOM_FILTER_INSERT_DEFINES_SVH
`define SIPHASH_BLOOM_FILTER_INSERT_DEFINES_SVH
// a condition that implies another in the same cycle
`define SBF_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: check failed");
// a condition that implies another in the next cycle
`define SBF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("%m: check failed");
`endif

@@ hdl/sbf_pkg.sv @@
// shared types, constants and functions of the bloom filter insert block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbf_pkg;
   localparam int FilterBitsDefault = 4096;
   localparam int HashLanesDefault  = 8;
   localparam int MaxLanes          = 8;
   localparam int ByteStreamLen     = MaxLanes * 8;

   localparam logic [1:0] OP_KEY_BYTE = 2'd0;
   localparam logic [1:0] OP_CLEAR    = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam logic CSR_LOG2  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

   typedef logic [3:0][63:0] sip_state_type;

   // lane keys, k0 and k1 little-endian
   function automatic logic [127:0] lane_key(input logic [2:0] lane);
      logic [127:0] key_bytes;
      logic [127:0] k;
      case (lane)
         3'd0: key_bytes = 128'hb9660bf0467047c18875c49c54b9bd15;
         3'd1: key_bytes = 128'haaa154a2e0714b39bfe1dd2e9fc54a3b;
         3'd2: key_bytes = 128'h63fdaebecd824812a16e4126cbfaa0c8;
         3'd3: key_bytes = 128'h23be452932d2462d82035228fe3717f5;
         3'd4: key_bytes = 128'h563bbfee5a4f4339afaa9408dff0fc10;
         3'd5: key_bytes = 128'h3180c873c7ea46d3aa25750f9e4c0929;
         3'd6: key_bytes = 128'h7df7184b7ba444d5853c06e06553966d;
         default: key_bytes = 128'hf277e96f93b54e719a0c34883925bf35;
      endcase
      // byte j of the list becomes bit 8j
      for (int j = 0; j < 16; j++) begin
         k[8*j +: 8] = key_bytes[8*(15-j) +: 8];
      end
      return k;
   endfunction

   function automatic sip_state_type lane_init(input logic [2:0] lane);
      logic [127:0] k;
      sip_state_type v;
      k = lane_key(lane);
      v[0] = k[63:0] ^ SIP_C0;
      v[1] = k[127:64] ^ SIP_C1;
      v[2] = k[63:0] ^ SIP_C2;
      v[3] = k[127:64] ^ SIP_C3;
      return v;
   endfunction

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_state_type sip_round(input sip_state_type vi);
      sip_state_type v;
      v = vi;
      v[0] = v[0] + v[1]; v[1] = rotl(v[1], 13); v[1] = v[1] ^ v[0]; v[0] = rotl(v[0], 32);
      v[2] = v[2] + v[3]; v[3] = rotl(v[3], 16); v[3] = v[3] ^ v[2];
      v[0] = v[0] + v[3]; v[3] = rotl(v[3], 21); v[3] = v[3] ^ v[0];
      v[2] = v[2] + v[1]; v[1] = rotl(v[1], 17); v[1] = v[1] ^ v[2]; v[2] = rotl(v[2], 32);
      return v;
   endfunction

   // datapath commands from the controller
   typedef struct packed {
      logic absorb;      // merge byte into partial block
      logic pre_xor;     // v3 ^= m
      logic do_round;    // one sip round on all lanes
      logic post_xor;    // v0 ^= m
      logic fin_xor;     // v2 ^= ff
      logic lanes_init;  // return lanes to key values
      logic load_final;  // m = partial | len
      logic capture;     // latch hash stream
      logic clear_step;  // clear one filter word
      logic set_bit;     // read word for current group
      logic write_bit;   // write word back with the bit set
      logic next_group;
      logic read_word;
   } sbf_cmd_type;

   typedef struct packed {
      logic block_full;  // absorbed byte completed a block
      logic param_bad;
   } sbf_status_type;
endpackage
`default_nettype wire

@@ hdl/sbf_datapath.sv @@
// lanes, byte stream, index extraction and filter memory
// depends on sbf_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbf_datapath import sbf_pkg::*; #(
   parameter int FILTER_BITS = FilterBitsDefault,
   parameter int HASH_LANES  = HashLanesDefault,
   localparam int IDX_W  = $clog2(FILTER_BITS),
   localparam int WORDS  = (FILTER_BITS + 63) / 64,
   localparam int WADR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sbf_cmd_type cmd,
   output sbf_status_type   status,
   input  wire logic [7:0]  byte_in,
   input  wire logic [5:0]  word_index,
   input  wire logic [WADR_W-1:0] clear_addr,
   input  wire logic [3:0]  cfg_log2,
   input  wire logic [6:0]  cfg_count,
   output logic [11:0]      bit_index,
   output logic [63:0]      word_value
);
   localparam int MAX_L = IDX_W;

   sip_state_type lane_ff [HASH_LANES];
   sip_state_type lane_in [HASH_LANES];
   logic [63:0] partial_ff, msg_ff;
   logic [7:0]  len_ff;
   logic [ByteStreamLen*8-1:0] stream_ff;
   logic [ByteStreamLen*8-1:0] hash_stream;
   logic [63:0] mem [WORDS];
   logic [63:0] rd_ff;
   logic [3:0]  eff_l;
   logic [1:0]  w;
   logic [15:0] group;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] idx_mask;
   logic [8:0]  need;

   always_comb begin
      eff_l = cfg_log2;
      if ({1'b0, cfg_log2} > 5'(MAX_L)) eff_l = 4'(MAX_L);
      if (eff_l < 4'd3) eff_l = 4'd3;
      w = (eff_l > 4'd8) ? 2'd2 : 2'd1;
      need = {2'b0, cfg_count} * {7'b0, w};
      status.param_bad = (cfg_count == 7'd0) || (need > 9'(HASH_LANES * 8));
      status.block_full = (len_ff[2:0] == 3'd7);
      // stream head is byte 0; two-byte groups big-endian
      group = (w == 2'd2) ? {stream_ff[7:0], stream_ff[15:8]} : {8'b0, stream_ff[7:0]};
      idx_mask = IDX_W'((17'(1) << eff_l) - 17'(1));
      idx = IDX_W'(group) & idx_mask;
      bit_index = 12'(idx);
      word_value = rd_ff;
   end

   always_comb begin
      for (int l = 0; l < HASH_LANES; l++) begin
         lane_in[l] = lane_ff[l];
         if (cmd.pre_xor) lane_in[l][3] = lane_ff[l][3] ^ msg_ff;
         if (cmd.do_round) lane_in[l] = sip_round(lane_ff[l]);
         if (cmd.post_xor) lane_in[l][0] = lane_ff[l][0] ^ msg_ff;
         if (cmd.fin_xor) lane_in[l][2] = lane_ff[l][2] ^ 64'hff;
         if (cmd.lanes_init || reset) lane_in[l] = lane_init(3'(l));
      end
   end

   always_comb begin
      hash_stream = '0;
      for (int l = 0; l < HASH_LANES; l++)
         hash_stream[l*64 +: 64] = lane_ff[l][0] ^ lane_ff[l][1] ^ lane_ff[l][2]
                                   ^ lane_ff[l][3];
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < HASH_LANES; l++) lane_ff[l] <= lane_in[l];
      if (reset || cmd.lanes_init) begin
         partial_ff <= '0;
         len_ff <= '0;
      end else if (cmd.absorb) begin
         partial_ff <= (len_ff[2:0] == 3'd7) ? '0
                       : partial_ff | (64'(byte_in) << {len_ff[2:0], 3'b0});
         len_ff <= len_ff + 8'd1;
      end else if (cmd.post_xor) begin
         partial_ff <= partial_ff;
      end
      if (cmd.load_final) msg_ff <= partial_ff | {len_ff, 56'b0};
      else if (cmd.absorb && len_ff[2:0] == 3'd7)
         msg_ff <= partial_ff | (64'(byte_in) << 56);
      if (cmd.capture) begin
         stream_ff <= hash_stream;
      end else if (cmd.next_group) begin
         stream_ff <= (w == 2'd2) ? (stream_ff >> 16) : (stream_ff >> 8);
      end
   end

   logic [WADR_W-1:0] set_addr, rd_addr, wr_addr_ff;
   logic [63:0] set_mask_ff;
   assign set_addr = WADR_W'(idx >> 6);
   assign rd_addr = WADR_W'(word_index);

   // read-modify-write for set: rd_ff holds word, written next cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clear_addr] <= '0;
      else if (cmd.write_bit) mem[wr_addr_ff] <= rd_ff | set_mask_ff;
      if (cmd.read_word)
         rd_ff <= (32'(word_index) < WORDS) ? mem[rd_addr] : '0;
      else if (cmd.set_bit)
         rd_ff <= mem[set_addr];
      if (cmd.set_bit) begin
         wr_addr_ff <= set_addr;
         set_mask_ff <= 64'(1) << 6'(idx);
      end
   end
endmodule
`default_nettype wire

@@ hdl/sbf_control.sv @@
// controller state machine for absorb, finalize, emit, clear and read
// depends on sbf_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbf_control import sbf_pkg::*; #(
   parameter int WADR_W = 6,
   parameter int WORDS = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [1:0]     req_operation,
   input  wire logic           req_last_byte,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_param_error,
   output logic                rsp_last_of_run,
   output logic                rsp_is_read,
   input  wire sbf_status_type status,
   input  wire logic [6:0]     cfg_count,
   output sbf_cmd_type         cmd,
   output logic [WADR_W-1:0]   clear_addr,
   output logic                busy
);
   typedef enum logic [3:0] {
      S_IDLE, S_COMP, S_FINAL, S_FROUND, S_CAPTURE, S_EMIT, S_SET, S_ERR, S_CLEAR, S_READ
   } state_type;
   state_type state_ff;
   logic [2:0] phase_ff;   // round counter
   logic       fin_ff;     // in finalization compress
   logic       final_done_ff;  // final block compress has run
   logic [6:0] cnt_ff;
   logic [WADR_W:0] clr_ff;
   logic accept;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign busy = req_stall;
   assign clear_addr = clr_ff[WADR_W-1:0];

   always_comb begin
      cmd = '0;
      rsp_valid = 1'b0;
      rsp_param_error = 1'b0;
      rsp_last_of_run = 1'b1;
      rsp_is_read = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_operation == OP_KEY_BYTE) cmd.absorb = 1'b1;
            if (accept && req_operation == OP_READ) cmd.read_word = 1'b1;
         end
         S_COMP: begin
            if (phase_ff == 3'd0) cmd.pre_xor = 1'b1;
            else if (phase_ff == 3'd3) cmd.post_xor = 1'b1;
            else cmd.do_round = 1'b1;
         end
         S_FINAL: cmd.load_final = 1'b1;
         S_FROUND: begin
            if (phase_ff == 3'd0) cmd.fin_xor = 1'b1;
            else cmd.do_round = 1'b1;
         end
         S_CAPTURE: cmd.capture = 1'b1;
         S_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last_of_run = (cnt_ff == 7'd1);
            if (!rsp_stall) begin
               cmd.set_bit = 1'b1;
               cmd.next_group = 1'b1;
               if (cnt_ff == 7'd1) cmd.lanes_init = 1'b1;
            end
         end
         S_SET: cmd.write_bit = 1'b1;
         S_ERR: begin
            rsp_valid = 1'b1;
            rsp_param_error = 1'b1;
            if (!rsp_stall) cmd.lanes_init = 1'b1;
         end
         S_CLEAR: cmd.clear_step = 1'b1;
         S_READ: begin
            rsp_valid = 1'b1;
            rsp_is_read = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= '0;
         fin_ff <= 1'b0;
         final_done_ff <= 1'b0;
         cnt_ff <= '0;
         clr_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     OP_KEY_BYTE: begin
                        fin_ff <= req_last_byte;
                        phase_ff <= '0;
                        if (status.block_full) state_ff <= S_COMP;
                        else if (req_last_byte) state_ff <= S_FINAL;
                     end
                     OP_CLEAR: begin
                        clr_ff <= '0;
                        state_ff <= S_CLEAR;
                     end
                     OP_READ: state_ff <= S_READ;
                     default: ;
                  endcase
               end
            end
            S_COMP: begin
               if (phase_ff == 3'd3) begin
                  phase_ff <= '0;
                  fin_ff <= 1'b0;
                  if (!fin_ff) state_ff <= S_IDLE;
                  else if (final_done_ff) state_ff <= S_FROUND;
                  else state_ff <= S_FINAL;
               end else begin
                  phase_ff <= phase_ff + 3'd1;
               end
            end
            S_FINAL: begin
               phase_ff <= '0;
               fin_ff <= 1'b1;
               final_done_ff <= 1'b1;
               state_ff <= S_COMP;
            end
            S_FROUND: begin
               phase_ff <= phase_ff + 3'd1;
               if (phase_ff == 3'd4) state_ff <= S_CAPTURE;
            end
            S_CAPTURE: begin
               final_done_ff <= 1'b0;
               cnt_ff <= cfg_count;
               state_ff <= status.param_bad ? S_ERR : S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_stall) begin
                  cnt_ff <= cnt_ff - 7'd1;
                  state_ff <= S_SET;
               end
            end
            S_SET: state_ff <= (cnt_ff == 7'd0) ? S_IDLE : S_EMIT;
            S_ERR: if (!rsp_stall) state_ff <= S_IDLE;
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == WORDS - 1) state_ff <= S_IDLE;
            end
            S_READ: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hdl/siphash_bloom_filter_insert.sv @@
// bloom filter insert: a key byte is absorbed while idle, and one that completes a block
// also runs a compression; a last byte then finalizes and captures the hash stream, then
// hash_count results follow, each set by a read-modify-write, or one error response
// clear zeroes one filter word per cycle, a read answers in the cycle after accept
// synchronous active-high reset restores lanes and registers and starts a clearing
// pass of one filter word per cycle (64 by default) with the input stalled
`timescale 1ns / 1ps
`default_nettype none
module siphash_bloom_filter_insert import sbf_pkg::*; #(
   parameter int FILTER_BITS = FilterBitsDefault,
   parameter int HASH_LANES  = HashLanesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [5:0]  req_word_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_bit_index,
   output logic [63:0]      rsp_word_value,
   output logic             rsp_param_error,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [6:0]  csr_data
);
   localparam int WORDS  = (FILTER_BITS + 63) / 64;
   localparam int WADR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   sbf_cmd_type cmd;
   sbf_status_type status;
   logic [3:0] log2_ff;
   logic [6:0] count_ff;
   logic [WADR_W-1:0] clear_addr;
   logic busy, is_read;
   logic [11:0] bidx;
   logic [63:0] wval;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= 4'd12;
         count_ff <= 7'd8;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOG2: log2_ff <= csr_data[3:0];
            CSR_COUNT: count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sbf_control #(.WADR_W(WADR_W), .WORDS(WORDS)) u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_last_byte,
      .rsp_valid, .rsp_stall, .rsp_param_error, .rsp_last_of_run,
      .rsp_is_read(is_read), .status, .cfg_count(count_ff), .cmd, .clear_addr, .busy
   );

   sbf_datapath #(.FILTER_BITS(FILTER_BITS), .HASH_LANES(HASH_LANES)) u_dp (
      .clock, .reset, .cmd, .status, .byte_in(req_data_byte),
      .word_index(req_word_index), .clear_addr, .cfg_log2(log2_ff),
      .cfg_count(count_ff), .bit_index(bidx), .word_value(wval)
   );

   assign rsp_bit_index = (is_read || rsp_param_error || !busy) ? 12'd0 : bidx;
   assign rsp_word_value = is_read ? wval : 64'd0;
endmodule
`default_nettype wire

@@ hdl/sbf_checker.sv @@
// port-level checks for the bloom filter insert block
// depends on siphash_bloom_filter_insert_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "siphash_bloom_filter_insert_defines.svh"
module sbf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_param_error,
   input wire logic        rsp_last_of_run,
   input wire logic [11:0] rsp_bit_index,
   input wire logic [63:0] rsp_word_value
);
   `SBF_ASSERT_IMPLY(a_err_last, clock, reset, rsp_valid && rsp_param_error, rsp_last_of_run)
   `SBF_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_param_error,
      rsp_bit_index == 12'd0 && rsp_word_value == 64'd0)
   `SBF_ASSERT_IMPLY(a_busy, clock, reset, rsp_valid, req_stall)
   `SBF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule
bind siphash_bloom_filter_insert sbf_checker u_chk (.*);
`default_nettype wire
